[hw/rtl/cbm_pkg.sv]
// Shared types and constants of the cartridge bank mapper.
`default_nettype none
package cbm_pkg;

  localparam int unsigned RAM_BYTES   = 8192;
  localparam int unsigned RAM_AW      = $clog2(RAM_BYTES);
  localparam int unsigned OFFSET_BITS = 19;
  localparam int unsigned OFFSET_W    = 19;

  localparam logic [2:0] KIND_CPU_READ  = 3'd0;
  localparam logic [2:0] KIND_CPU_WRITE = 3'd1;
  localparam logic [2:0] KIND_PPU_READ  = 3'd2;
  localparam logic [2:0] KIND_TICK      = 3'd3;
  localparam logic [2:0] KIND_IRQ_CLEAR = 3'd4;

  localparam logic [1:0] GRP_BANK   = 2'd0;
  localparam logic [1:0] GRP_MIRROR = 2'd1;
  localparam logic [1:0] GRP_RELOAD = 2'd2;
  localparam logic [1:0] GRP_ENABLE = 2'd3;

  localparam logic [5:0] PRG_UNITS_RESET = 6'd2;

  typedef struct packed {
    logic                handled;
    logic                from_ram;
    logic                ram_read;
    logic [OFFSET_W-1:0] offset;
    logic                irq;
    logic                mirror;
  } res_t;

  typedef struct packed {
    logic              en;
    logic              we;
    logic [RAM_AW-1:0] addr;
    logic [7:0]        wdata;
  } ram_req_t;

endpackage
`default_nettype wire

[hw/rtl/cbm_if.sv]
// Item and result channel interfaces of the cartridge bank mapper.
`default_nettype none
interface cbm_item_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] address;
  logic [7:0]  write_data;
  modport source (output valid, kind, address, write_data, input ready);
  modport sink (input valid, kind, address, write_data, output ready);
endinterface

interface cbm_result_if;
  logic        valid;
  logic        ready;
  logic        handled;
  logic        from_ram;
  logic [18:0] mapped_offset;
  logic [7:0]  read_data;
  logic        irq_active;
  logic        mirror_horizontal;
  modport source (output valid, handled, from_ram, mapped_offset, read_data, irq_active,
                  mirror_horizontal, input ready);
  modport sink (input valid, handled, from_ram, mapped_offset, read_data, irq_active,
                mirror_horizontal, output ready);
endinterface
`default_nettype wire

[hw/rtl/cartridge_bank_mapper_irq.sv]
// Top level of the cartridge bank mapper with scanline interrupt counter.
// Banked cartridge mapper: one transaction in, one result out. A transaction is
// taken every cycle while the staging register is empty or its result can advance;
// at acceptance the 8 KiB cartridge RAM is read together with loading the staged
// result register, the output register loads from both when it is free, and the output
// register lets a new transaction enter while a finished result waits. Register
// writes and interrupt state take effect at acceptance. Reading RAM bytes never
// written since reset gives undefined data.
`default_nettype none
module cartridge_bank_mapper_irq #(
  parameter int unsigned OFFSET_BITS = cbm_pkg::OFFSET_BITS
) (
  input  wire logic       clk,
  input  wire logic       rst,
  cbm_item_if.sink        item,
  cbm_result_if.source    result,
  input  wire logic       cfg_wr_en,
  input  wire logic [5:0] cfg_wr_data
);

  cbm_pkg::res_t     res;
  cbm_pkg::ram_req_t ram_req;
  cbm_pkg::res_t     s1_res;
  logic              s1_valid;
  logic              s1_adv;
  logic              accept;
  logic [7:0]        ram_rdata;

  assign s1_adv     = s1_valid && (!result.valid || result.ready);
  assign item.ready = !s1_valid || s1_adv;
  assign accept     = item.valid && item.ready;

  cbm_ctrl #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .kind        (item.kind),
    .address     (item.address),
    .write_data  (item.write_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .res         (res),
    .ram_req     (ram_req)
  );

  cbm_ram #(
    .WIDTH (8),
    .DEPTH (cbm_pkg::RAM_BYTES)
  ) u_ram (
    .clk   (clk),
    .en    (ram_req.en),
    .we    (ram_req.we),
    .addr  (ram_req.addr),
    .wdata (ram_req.wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res <= res;
    end
    if (s1_adv) begin
      result.handled           <= s1_res.handled;
      result.from_ram          <= s1_res.from_ram;
      result.mapped_offset     <= s1_res.offset;
      result.read_data         <= s1_res.ram_read ? ram_rdata : 8'd0;
      result.irq_active        <= s1_res.irq;
      result.mirror_horizontal <= s1_res.mirror;
    end
  end

`ifndef SYNTH
  a_ram_only_on_accept: assert property (@(posedge clk) disable iff (rst)
    ram_req.en |-> accept)
    else $error("RAM access without an accepted transaction");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted transaction lost before the output stage");

  a_no_accept_on_stall: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |-> !accept)
    else $error("transaction accepted while the RAM stage is stalled");

  a_ram_result_unmapped: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.from_ram) |-> (result.mapped_offset == '0))
    else $error("RAM access carries a ROM offset");

  a_unhandled_is_empty: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.handled) |-> (!result.from_ram && result.read_data == 8'd0))
    else $error("unhandled transaction carries data");
`endif

endmodule
`default_nettype wire

[hw/rtl/cbm_ram.sv]
// Generic single-port synchronous RAM with registered read.
`default_nettype none
module cbm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule
`default_nettype wire

[hw/rtl/cbm_ctrl.sv]
// Mapper registers, bus decode, bank translation and scanline counter.
`default_nettype none
module cbm_ctrl #(
  parameter int unsigned OFFSET_BITS = cbm_pkg::OFFSET_BITS
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire logic [2:0]       kind,
  input  wire logic [15:0]      address,
  input  wire logic [7:0]       write_data,
  input  wire logic             cfg_wr_en,
  input  wire logic [5:0]       cfg_wr_data,
  output cbm_pkg::res_t         res,
  output cbm_pkg::ram_req_t     ram_req
);

  localparam logic [cbm_pkg::OFFSET_W-1:0] OFFSET_MASK = '1 >> (cbm_pkg::OFFSET_W - OFFSET_BITS);

  logic [7:0] bank_regs [8];
  logic [2:0] target_select;
  logic       prg_swap_mode;
  logic       chr_invert;
  logic       mirror_bit;
  logic [7:0] irq_reload_value;
  logic [7:0] irq_count;
  logic       irq_enabled;
  logic       irq_flag;
  logic [5:0] prg_units;

  logic       in_ram_win;
  logic       in_reg_win;
  logic       cpu_rd;
  logic       cpu_wr;
  logic       ppu_rd;
  logic       tick;
  logic       clear;
  logic       reg_wr;
  logic       odd;
  logic [1:0] grp;
  logic [5:0] last_bank;
  logic [5:0] second_bank;
  logic [5:0] prg_bank;
  logic [2:0] chr_win;
  logic [7:0] chr_reg;
  logic [7:0] chr_bank;
  logic [cbm_pkg::OFFSET_W-1:0] prg_off;
  logic [cbm_pkg::OFFSET_W-1:0] chr_off;
  logic [7:0] irq_count_next;
  logic       irq_enabled_next;
  logic       irq_flag_next;
  logic       mirror_bit_next;

  assign in_ram_win = (address[15:13] == 3'b011);
  assign in_reg_win = address[15];
  assign cpu_rd     = (kind == cbm_pkg::KIND_CPU_READ);
  assign cpu_wr     = (kind == cbm_pkg::KIND_CPU_WRITE);
  assign ppu_rd     = (kind == cbm_pkg::KIND_PPU_READ) && (address[15:13] == 3'b000);
  assign tick       = (kind == cbm_pkg::KIND_TICK);
  assign clear      = (kind == cbm_pkg::KIND_IRQ_CLEAR);
  assign reg_wr     = cpu_wr && in_reg_win;
  assign odd        = address[0];
  assign grp        = address[14:13];

  assign last_bank   = {prg_units[4:0], 1'b0} - 6'd1;
  assign second_bank = {prg_units[4:0], 1'b0} - 6'd2;

  always_comb begin
    case (address[14:13])
      2'd0:    prg_bank = prg_swap_mode ? second_bank : bank_regs[6][5:0];
      2'd1:    prg_bank = bank_regs[7][5:0];
      2'd2:    prg_bank = prg_swap_mode ? bank_regs[6][5:0] : second_bank;
      default: prg_bank = last_bank;
    endcase
  end

  assign chr_win = address[12:10] ^ {chr_invert, 2'b00};
  assign chr_reg = chr_win[2] ? bank_regs[{1'b0, chr_win[1:0]} + 3'd2]
                              : bank_regs[{2'b00, chr_win[1]}];
  assign chr_bank = chr_win[2] ? chr_reg
                  : (chr_win[0] ? (chr_reg | 8'h01) : (chr_reg & 8'hfe));

  assign prg_off = {prg_bank, address[12:0]} & OFFSET_MASK;
  assign chr_off = {1'b0, chr_bank, address[9:0]} & OFFSET_MASK;

  always_comb begin
    irq_count_next   = irq_count;
    irq_enabled_next = irq_enabled;
    irq_flag_next    = irq_flag;
    mirror_bit_next  = mirror_bit;
    if (tick) begin
      irq_count_next = (irq_count == 8'd0) ? irq_reload_value : irq_count - 8'd1;
      if ((irq_count_next == 8'd0) && irq_enabled) begin
        irq_flag_next = 1'b1;
      end
    end else if (clear) begin
      irq_flag_next = 1'b0;
    end else if (reg_wr) begin
      case (grp)
        cbm_pkg::GRP_MIRROR: begin
          if (!odd) begin
            mirror_bit_next = write_data[0];
          end
        end
        cbm_pkg::GRP_RELOAD: begin
          if (odd) begin
            irq_count_next = 8'd0;
          end
        end
        cbm_pkg::GRP_ENABLE: begin
          if (odd) begin
            irq_enabled_next = 1'b1;
          end else begin
            irq_enabled_next = 1'b0;
            irq_flag_next    = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) begin
        bank_regs[i] <= 8'd0;
      end
      target_select    <= 3'd0;
      prg_swap_mode    <= 1'b0;
      chr_invert       <= 1'b0;
      mirror_bit       <= 1'b1;
      irq_reload_value <= 8'd0;
      irq_count        <= 8'd0;
      irq_enabled      <= 1'b0;
      irq_flag         <= 1'b0;
      prg_units        <= cbm_pkg::PRG_UNITS_RESET;
    end else begin
      if (cfg_wr_en) begin
        prg_units <= cfg_wr_data;
      end
      if (accept) begin
        irq_count   <= irq_count_next;
        irq_enabled <= irq_enabled_next;
        irq_flag    <= irq_flag_next;
        mirror_bit  <= mirror_bit_next;
        if (reg_wr && (grp == cbm_pkg::GRP_BANK)) begin
          if (odd) begin
            bank_regs[target_select] <= write_data;
          end else begin
            target_select <= write_data[2:0];
            prg_swap_mode <= write_data[6];
            chr_invert    <= write_data[7];
          end
        end
        if (reg_wr && (grp == cbm_pkg::GRP_RELOAD) && !odd) begin
          irq_reload_value <= write_data;
        end
      end
    end
  end

  always_comb begin
    res          = '0;
    res.irq      = irq_flag_next;
    res.mirror   = mirror_bit_next;
    if ((cpu_rd || cpu_wr) && in_ram_win) begin
      res.handled  = 1'b1;
      res.from_ram = 1'b1;
      res.ram_read = cpu_rd;
    end else if (cpu_rd && in_reg_win) begin
      res.handled = 1'b1;
      res.offset  = prg_off;
    end else if (ppu_rd) begin
      res.handled = 1'b1;
      res.offset  = chr_off;
    end
  end

  assign ram_req.en    = accept && (cpu_rd || cpu_wr) && in_ram_win;
  assign ram_req.we    = cpu_wr;
  assign ram_req.addr  = address[cbm_pkg::RAM_AW-1:0];
  assign ram_req.wdata = write_data;

endmodule
`default_nettype wire

[test/cbm_result_checker.sv]
// Result checker for the cartridge bank mapper: predicts each transaction and compares results.
module cbm_result_checker (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wr_en,
  input  wire logic [5:0] cfg_wr_data,
  cbm_item_if             item,
  cbm_result_if           result,
  output int              mismatches,
  output int              outstanding
);
  import cbm_pkg::*;

  typedef struct packed {
    logic        handled;
    logic        from_ram;
    logic [18:0] offset;
    logic [7:0]  rdata;
    logic        irq;
    logic        mirror;
  } bus_result_t;

  logic [7:0]  cart_ram [RAM_BYTES];
  logic [7:0]  bank [8];
  logic [2:0]  target;
  logic        prg_swap;
  logic        chr_inv;
  logic        mirror_h;
  logic [7:0]  reload;
  logic [7:0]  count;
  logic        irq_en;
  logic        irq_flag;
  logic [5:0]  prg_units = PRG_UNITS_RESET;
  bus_result_t awaited_results [$];
  int          fail_cnt = 0;

  function automatic logic [18:0] prg_rom_offset(logic [15:0] a);
    logic [5:0] last_bank;
    logic [5:0] second_bank;
    logic [5:0] r6;
    logic [5:0] sel;
    last_bank   = {prg_units[4:0], 1'b0} - 6'd1;
    second_bank = {prg_units[4:0], 1'b0} - 6'd2;
    r6          = bank[6][5:0];
    case (a[14:13])
      2'd0: sel = prg_swap ? second_bank : r6;
      2'd1: sel = bank[7][5:0];
      2'd2: sel = prg_swap ? r6 : second_bank;
      default: sel = last_bank;
    endcase
    return {sel, a[12:0]};
  endfunction

  function automatic logic [18:0] chr_rom_offset(logic [15:0] a);
    logic [2:0] win;
    logic [7:0] sel;
    win = a[12:10] ^ {chr_inv, 2'b00};
    if (!win[2]) begin
      sel = bank[{2'b00, win[1]}];
      sel = win[0] ? (sel | 8'h01) : (sel & 8'hfe);
    end else begin
      sel = bank[3'd2 + {1'b0, win[1:0]}];
    end
    return {1'b0, sel, a[9:0]};
  endfunction

  function automatic void write_register(logic [15:0] a, logic [7:0] d);
    case (a[14:13])
      GRP_BANK: begin
        if (!a[0]) begin
          target   = d[2:0];
          prg_swap = d[6];
          chr_inv  = d[7];
        end else begin
          bank[target] = d;
        end
      end
      GRP_MIRROR: begin
        if (!a[0]) mirror_h = d[0];
      end
      GRP_RELOAD: begin
        if (!a[0]) reload = d;
        else count = 8'd0;
      end
      default: begin
        if (!a[0]) begin
          irq_en   = 1'b0;
          irq_flag = 1'b0;
        end else begin
          irq_en = 1'b1;
        end
      end
    endcase
  endfunction

  function automatic bus_result_t advance_mapper(logic [2:0] k, logic [15:0] a, logic [7:0] d);
    bus_result_t r;
    r = '0;
    case (k)
      KIND_CPU_READ: begin
        if (a[15:13] == 3'b011) begin
          r.handled  = 1'b1;
          r.from_ram = 1'b1;
          r.rdata    = cart_ram[a[12:0]];
        end else if (a[15]) begin
          r.handled = 1'b1;
          r.offset  = prg_rom_offset(a);
        end
      end
      KIND_CPU_WRITE: begin
        if (a[15:13] == 3'b011) begin
          r.handled         = 1'b1;
          r.from_ram        = 1'b1;
          cart_ram[a[12:0]] = d;
        end else if (a[15]) begin
          write_register(a, d);
        end
      end
      KIND_PPU_READ: begin
        if (a[15:13] == 3'b000) begin
          r.handled = 1'b1;
          r.offset  = chr_rom_offset(a);
        end
      end
      KIND_TICK: begin
        count = (count == 8'd0) ? reload : count - 8'd1;
        if (count == 8'd0 && irq_en) irq_flag = 1'b1;
      end
      KIND_IRQ_CLEAR: irq_flag = 1'b0;
      default: ;
    endcase
    r.irq    = irq_flag;
    r.mirror = mirror_h;
    return r;
  endfunction

  function automatic string show(bus_result_t r);
    return $sformatf("handled=%0b from_ram=%0b offset=%05h read_data=%02h irq=%0b mirror=%0b",
                     r.handled, r.from_ram, r.offset, r.rdata, r.irq, r.mirror);
  endfunction

  always @(posedge clk) begin
    bus_result_t got;
    bus_result_t want;
    if (rst) begin
      for (int i = 0; i < 8; i++) bank[i] = 8'd0;
      target    = 3'd0;
      prg_swap  = 1'b0;
      chr_inv   = 1'b0;
      mirror_h  = 1'b1;
      reload    = 8'd0;
      count     = 8'd0;
      irq_en    = 1'b0;
      irq_flag  = 1'b0;
      prg_units = PRG_UNITS_RESET;
      awaited_results.delete();
    end else begin
      if (result.valid && result.ready) begin
        got.handled  = result.handled;
        got.from_ram = result.from_ram;
        got.offset   = result.mapped_offset;
        got.rdata    = result.read_data;
        got.irq      = result.irq_active;
        got.mirror   = result.mirror_horizontal;
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %s", $time, show(got));
          fail_cnt++;
        end else begin
          want = awaited_results.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch, expected %s, actual %s", $time, show(want), show(got));
            fail_cnt++;
          end
        end
      end
      if (cfg_wr_en) prg_units = cfg_wr_data;
      if (item.valid && item.ready) begin
        awaited_results.push_back(advance_mapper(item.kind, item.address, item.write_data));
      end
    end
    mismatches  <= fail_cnt;
    outstanding <= awaited_results.size();
  end

endmodule

[test/tb_cartridge_bank_mapper_irq.sv]
// Testbench top for the cartridge bank mapper: directed and random transactions, verdict.
module tb_cartridge_bank_mapper_irq;
  import cbm_pkg::*;

  localparam logic [2:0] KIND_RESERVED = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [5:0]  cfg_wr_data = '0;
  logic        rx_ready = 1'b0;
  int          rx_stall_pct = 0;
  int          tx_idle_pct = 0;
  int          accesses_sent = 0;
  int          mismatches;
  int          outstanding;
  bit          ram_written [RAM_BYTES];
  logic [12:0] ram_used [$];
  logic [5:0]  units_plan [8] = '{6'd1, 6'd32, 6'd63, 6'd0, 6'd0, 6'd5, 6'd32, 6'd2};

  cbm_item_if   item_ch ();
  cbm_result_if result_ch ();

  assign result_ch.ready = rx_ready;

  cartridge_bank_mapper_irq uut (
    .clk         (clk),
    .rst         (rst),
    .item        (item_ch),
    .result      (result_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  cbm_result_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item        (item_ch),
    .result      (result_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    rx_ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  initial begin
    #2000000;
    $display("tb_cartridge_bank_mapper_irq: FAIL");
    $finish;
  end

  task automatic send(logic [2:0] k, logic [15:0] a, logic [7:0] d);
    while ($urandom_range(99) < tx_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid      <= 1'b1;
    item_ch.kind       <= k;
    item_ch.address    <= a;
    item_ch.write_data <= d;
    if (k == KIND_CPU_WRITE && a[15:13] == 3'b011 && !ram_written[a[12:0]]) begin
      ram_written[a[12:0]] = 1'b1;
      ram_used.push_back(a[12:0]);
    end
    if (k <= KIND_IRQ_CLEAR) accesses_sent++;
    do @(posedge clk); while (!item_ch.ready);
  endtask

  task automatic drain();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic set_units(logic [5:0] u);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= u;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_access();
    int unsigned pick;
    logic [15:0] a;
    logic [15:0] b;
    logic [7:0]  d;
    pick = $urandom_range(99);
    a    = 16'($urandom);
    b    = 16'($urandom);
    d    = 8'($urandom);
    if (pick < 14) begin
      send(KIND_CPU_WRITE, {3'b011, a[12:0]}, d);
    end else if (pick < 28) begin
      if (ram_used.size() == 0) send(KIND_CPU_WRITE, {3'b011, a[12:0]}, d);
      else send(KIND_CPU_READ, {3'b011, ram_used[$urandom_range(ram_used.size() - 1)]}, d);
    end else if (pick < 42) begin
      send(KIND_CPU_READ, {1'b1, a[14:0]}, d);
    end else if (pick < 58) begin
      send(KIND_PPU_READ, {3'b000, a[12:0]}, d);
    end else if (pick < 64) begin
      send(KIND_CPU_WRITE, {1'b1, GRP_BANK, a[12:1], 1'b0}, d);
      send(KIND_CPU_WRITE, {1'b1, GRP_BANK, b[12:1], 1'b1}, 8'($urandom));
    end else if (pick < 67) begin
      send(KIND_CPU_WRITE, {1'b1, GRP_MIRROR, a[12:0]}, d);
    end else if (pick < 72) begin
      if ($urandom_range(3) != 0) d = 8'($urandom_range(7));
      send(KIND_CPU_WRITE, {1'b1, GRP_RELOAD, a[12:1], 1'b0}, d);
    end else if (pick < 74) begin
      send(KIND_CPU_WRITE, {1'b1, GRP_RELOAD, a[12:1], 1'b1}, d);
    end else if (pick < 77) begin
      send(KIND_CPU_WRITE, {1'b1, GRP_ENABLE, a[12:0]}, d);
    end else if (pick < 91) begin
      send(KIND_TICK, a, d);
    end else if (pick < 94) begin
      send(KIND_IRQ_CLEAR, a, d);
    end else if (pick < 95) begin
      send(KIND_CPU_READ, 16'($urandom_range(16'h5fff)), d);
    end else if (pick < 96) begin
      send(KIND_CPU_WRITE, 16'($urandom_range(16'h5fff)), d);
    end else if (pick < 97) begin
      send(KIND_PPU_READ, 16'($urandom_range(16'hffff, 16'h2000)), d);
    end else begin
      send(3'($urandom_range(KIND_RESERVED, KIND_IRQ_CLEAR + 3'd1)), a, d);
    end
  endtask

  initial begin
    int  stop;
    bit  paused;
    item_ch.valid      <= 1'b0;
    item_ch.kind       <= KIND_TICK;
    item_ch.address    <= 16'h0000;
    item_ch.write_data <= 8'h00;
    paused = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send(KIND_CPU_WRITE, 16'h6000, 8'h00);
    send(KIND_CPU_WRITE, 16'h7fff, 8'hff);
    send(KIND_CPU_READ, 16'h7fff, 8'h00);
    send(KIND_CPU_READ, 16'h6000, 8'hff);
    send(KIND_CPU_READ, 16'h5fff, 8'h00);
    send(KIND_CPU_WRITE, 16'h0000, 8'hff);
    send(KIND_PPU_READ, 16'h2000, 8'h00);
    send(KIND_PPU_READ, 16'hffff, 8'h00);
    send(KIND_CPU_READ, 16'h8000, 8'h00);
    send(KIND_CPU_READ, 16'hffff, 8'h00);
    send(KIND_CPU_WRITE, 16'h8000, 8'hc6);
    send(KIND_CPU_WRITE, 16'h8001, 8'hff);
    send(KIND_CPU_READ, 16'h8000, 8'h00);
    send(KIND_CPU_READ, 16'hdfff, 8'h00);
    send(KIND_CPU_WRITE, 16'h8000, 8'h80);
    send(KIND_CPU_WRITE, 16'h8001, 8'h81);
    send(KIND_PPU_READ, 16'h1000, 8'h00);
    send(KIND_PPU_READ, 16'h17ff, 8'h00);
    send(KIND_PPU_READ, 16'h0000, 8'h00);
    send(KIND_CPU_WRITE, 16'ha000, 8'hfe);
    send(KIND_CPU_WRITE, 16'hc000, 8'h01);
    send(KIND_CPU_WRITE, 16'hc001, 8'h00);
    send(KIND_CPU_WRITE, 16'he001, 8'h00);
    send(KIND_TICK, 16'h0000, 8'h00);
    send(KIND_TICK, 16'hffff, 8'hff);
    send(KIND_IRQ_CLEAR, 16'h0000, 8'h00);
    send(KIND_RESERVED, 16'hffff, 8'hff);
    send(KIND_CPU_WRITE, 16'he000, 8'h00);

    for (int p = 0; p < 8; p++) begin
      set_units(p == 4 ? 6'($urandom_range(31, 1)) : units_plan[p]);
      case (p % 4)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct  = 77;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 77;
        end
        default: begin
          tx_idle_pct  = 8;
          rx_stall_pct = 8;
        end
      endcase
      stop = accesses_sent + 140;
      while (accesses_sent < stop) begin
        random_access();
        if (p == 5 && !paused && accesses_sent >= stop - 70) begin
          drain();
          paused = 1'b1;
        end
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_cartridge_bank_mapper_irq: PASS");
    end else begin
      $display("tb_cartridge_bank_mapper_irq: FAIL");
    end
    $finish;
  end

endmodule
